### sv/binary_min_heap_event_queue_defines.svh
// assertion macros shared by the event queue rtl
`ifndef BINARY_MIN_HEAP_EVENT_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BMHQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bmhq assertion failed");

// next-cycle implication, disabled during reset
`define BMHQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bmhq assertion failed");

`endif

### sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// types, codes and defaults for the min-heap event queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int DEF_HEAP_SLOTS  = 1024;
  localparam int DEF_AGENT_COUNT = 1024;
  localparam int DEF_TIME_BITS   = 32;

  localparam int AGENT_W    = 10;
  localparam int OUT_TIME_W = 32;
  localparam int OCC_W      = 11;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DELETE = 2'd2,
    OP_PEEK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef struct packed {
    op_e                   operation;
    logic [AGENT_W-1:0]    agent_id;
    logic [OUT_TIME_W-1:0] event_time;
  } in_t;

  typedef struct packed {
    status_e               status;
    logic [AGENT_W-1:0]    top_agent;
    logic [OUT_TIME_W-1:0] top_time;
    logic [OCC_W-1:0]      occupancy;
  } out_t;

endpackage

### sv/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/binary_min_heap_event_queue.sv
// throughput: one operation at a time, set by the single read port of the heap ram
// reset: entry count and control clear at once; ram contents stay undefined
// and need no clearing pass
// ----------------------------------------------------------------------------
// binary_min_heap_event_queue
// heap of (time, agent) entries in ram with an agent position map in ram
// ----------------------------------------------------------------------------
`include "binary_min_heap_event_queue_defines.svh"

module binary_min_heap_event_queue import bmhq_pkg::*; #(
  parameter int HEAP_SLOTS  = DEF_HEAP_SLOTS,
  parameter int AGENT_COUNT = DEF_AGENT_COUNT,
  parameter int TIME_BITS   = DEF_TIME_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int SW  = $clog2(HEAP_SLOTS);
  localparam int CW  = $clog2(HEAP_SLOTS + 1);
  localparam int AIW = $clog2(AGENT_COUNT);
  localparam int EW  = AGENT_W + TIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_ROOT_WAIT, S_DS_WAIT, S_DV_WAIT, S_LAST_WAIT, S_UP, S_UP_WAIT,
    S_DOWN, S_L_WAIT, S_R_WAIT, S_MOVE, S_FINAL, S_FIN
  } state_e;

  state_e                 state_q;
  logic [CW-1:0]          count_q;
  logic [SW-1:0]          k_q;
  logic [TIME_BITS-1:0]   cur_t_q, bt_q, victim_t_q, top_t_q;
  logic [AGENT_W-1:0]     cur_a_q, ba_q, agent_q, top_a_q;
  logic [SW-1:0]          bi_q;
  logic                   sel_q;
  op_e                    op_q;
  status_e                status_q;
  out_t                   out_q;
  logic                   out_valid_q;

  logic                   h_we, s_we;
  logic [SW-1:0]          h_waddr, h_raddr, s_wdata;
  logic [EW-1:0]          h_wdata, h_rdata;
  logic [AIW-1:0]         s_waddr, s_raddr;
  logic [SW-1:0]          s_rdata;

  logic [TIME_BITS-1:0]   rd_t;
  logic [AGENT_W-1:0]     rd_a;
  logic [SW:0]            left;
  logic [SW+1:0]          right;
  logic [SW-1:0]          parent;
  logic [SW-1:0]          last_idx;
  logic                   accept;

  assign rd_t     = h_rdata[TIME_BITS-1:0];
  assign rd_a     = h_rdata[EW-1:TIME_BITS];
  assign left     = {k_q, 1'b1};
  assign right    = (SW+2)'(left) + (SW+2)'(1);
  assign parent   = SW'((k_q - SW'(1)) >> 1);
  assign last_idx = SW'(count_q - CW'(1));
  assign accept   = in_valid_i && in_ready_o;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    h_we    = 1'b0;
    h_waddr = k_q;
    h_wdata = {cur_a_q, cur_t_q};
    h_raddr = '0;
    s_we    = 1'b0;
    s_waddr = AIW'(cur_a_q);
    s_wdata = k_q;
    s_raddr = AIW'(in_data_i.agent_id);
    case (state_q)
      S_ROOT_WAIT: h_raddr = last_idx;
      S_DS_WAIT:   h_raddr = s_rdata;
      S_DV_WAIT:   h_raddr = last_idx;
      S_UP:        h_raddr = parent;
      S_UP_WAIT: begin
        if (cur_t_q < rd_t) begin
          h_we    = 1'b1;
          h_wdata = h_rdata;
          s_we    = 1'b1;
          s_waddr = AIW'(rd_a);
        end
      end
      S_DOWN:      h_raddr = SW'(left);
      S_L_WAIT:    h_raddr = SW'(right);
      S_MOVE: begin
        if (sel_q) begin
          h_we    = 1'b1;
          h_wdata = {ba_q, bt_q};
          s_we    = 1'b1;
          s_waddr = AIW'(ba_q);
        end
      end
      S_FINAL: begin
        h_we = 1'b1;
        s_we = 1'b1;
      end
      default: ;
    endcase
  end

  bmhq_ram #(.WIDTH(EW), .DEPTH(HEAP_SLOTS)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  bmhq_ram #(.WIDTH(SW), .DEPTH(AGENT_COUNT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the final state reloads the result register itself
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q     <= in_data_i.operation;
            agent_q  <= in_data_i.agent_id;
            status_q <= ST_OK;
            top_a_q  <= '0;
            top_t_q  <= '0;
            cur_t_q  <= TIME_BITS'(in_data_i.event_time);
            cur_a_q  <= in_data_i.agent_id;
            case (in_data_i.operation)
              OP_INSERT: begin
                if (32'(in_data_i.agent_id) >= AGENT_COUNT) begin
                  status_q <= ST_BAD;
                  state_q  <= S_FIN;
                end else if (32'(count_q) >= HEAP_SLOTS) begin
                  status_q <= ST_FULL;
                  state_q  <= S_FIN;
                end else begin
                  k_q     <= SW'(count_q);
                  count_q <= count_q + CW'(1);
                  state_q <= S_UP;
                end
              end
              OP_DELETE: begin
                if (32'(in_data_i.agent_id) >= AGENT_COUNT) begin
                  status_q <= ST_BAD;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_DS_WAIT;
                end
              end
              default: begin
                if (count_q == '0) begin
                  status_q <= ST_EMPTY;
                  top_t_q  <= '1;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_ROOT_WAIT;
                end
              end
            endcase
          end
        end
        S_ROOT_WAIT: begin
          top_a_q <= rd_a;
          top_t_q <= rd_t;
          k_q     <= '0;
          if (op_q == OP_PEEK) begin
            state_q <= S_FIN;
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= (count_q == CW'(1)) ? S_FIN : S_LAST_WAIT;
          end
        end
        S_DS_WAIT: begin
          k_q <= s_rdata;
          if ((SW+1)'(s_rdata) >= (SW+1)'(count_q)) begin
            status_q <= ST_BAD;
            state_q  <= S_FIN;
          end else begin
            state_q <= S_DV_WAIT;
          end
        end
        S_DV_WAIT: begin
          if (rd_a != agent_q) begin
            status_q <= ST_BAD;
            state_q  <= S_FIN;
          end else begin
            victim_t_q <= rd_t;
            count_q    <= count_q - CW'(1);
            // victim is the last entry: the array just shrinks
            if (count_q == CW'(1) || k_q == last_idx) begin
              state_q <= S_FIN;
            end else begin
              state_q <= S_LAST_WAIT;
            end
          end
        end
        S_LAST_WAIT: begin
          cur_t_q <= rd_t;
          cur_a_q <= rd_a;
          if (op_q == OP_DELETE && rd_t <= victim_t_q) begin
            state_q <= S_UP;
          end else begin
            state_q <= S_DOWN;
          end
        end
        S_UP: begin
          state_q <= (k_q == '0) ? S_FINAL : S_UP_WAIT;
        end
        S_UP_WAIT: begin
          // parent slides down into the hole
          if (cur_t_q < rd_t) begin
            k_q     <= parent;
            state_q <= S_UP;
          end else begin
            state_q <= S_FINAL;
          end
        end
        S_DOWN: begin
          if ((SW+2)'(left) >= (SW+2)'(count_q)) begin
            state_q <= S_FINAL;
          end else begin
            state_q <= S_L_WAIT;
          end
        end
        S_L_WAIT: begin
          if (rd_t < cur_t_q) begin
            bt_q  <= rd_t;
            ba_q  <= rd_a;
            bi_q  <= SW'(left);
            sel_q <= 1'b1;
          end else begin
            bt_q  <= cur_t_q;
            sel_q <= 1'b0;
          end
          state_q <= (right < (SW+2)'(count_q)) ? S_R_WAIT : S_MOVE;
        end
        S_R_WAIT: begin
          if (rd_t < bt_q) begin
            bt_q  <= rd_t;
            ba_q  <= rd_a;
            bi_q  <= SW'(right);
            sel_q <= 1'b1;
          end
          state_q <= S_MOVE;
        end
        S_MOVE: begin
          if (sel_q) begin
            k_q     <= bi_q;
            state_q <= S_DOWN;
          end else begin
            state_q <= S_FINAL;
          end
        end
        S_FINAL: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.status    <= status_q;
            out_q.top_agent <= top_a_q;
            out_q.top_time  <= OUT_TIME_W'(top_t_q);
            out_q.occupancy <= OCC_W'(count_q);
            out_valid_q     <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BMHQ_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, 32'(count_q) <= HEAP_SLOTS)
  `BMHQ_ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, accept, !in_ready_o)
  `BMHQ_ASSERT_NOW(a_empty_occ, clk_i, rst_ni, out_valid_q && out_q.status == ST_EMPTY,
                   out_q.occupancy == '0)
  `BMHQ_ASSERT_NOW(a_single_write, clk_i, rst_ni, h_we, s_we)

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives heap operations through the event queue with random idling and
// back-pressure, predicts every result with a software heap and checks each
// result transfer against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bmhq_pkg::*;

  localparam int SLOTS  = DEF_HEAP_SLOTS;
  localparam int AGENTS = DEF_AGENT_COUNT;

  class heap_scoreboard;
    logic [31:0] key_q[SLOTS];
    logic [9:0]  who_q[SLOTS];
    int          slot_of[AGENTS];
    int          count;
    out_t        pending[$];
    int          errors;

    function new();
      count = 0;
      errors = 0;
      foreach (slot_of[i]) slot_of[i] = 0;
    endfunction

    function void place(int pos, logic [31:0] t, logic [9:0] a);
      key_q[pos] = t;
      who_q[pos] = a;
      slot_of[a] = pos;
    endfunction

    function void swap_slots(int x, int y);
      logic [31:0] t;
      logic [9:0]  a;
      t = key_q[x];
      a = who_q[x];
      place(x, key_q[y], who_q[y]);
      place(y, t, a);
    endfunction

    function void float_up(int k);
      int p;
      while (k > 0) begin
        p = (k - 1) / 2;
        if (key_q[k] < key_q[p]) begin
          swap_slots(k, p);
          k = p;
        end else begin
          break;
        end
      end
    endfunction

    function void sink(int k);
      int l;
      int best;
      forever begin
        l = 2 * k + 1;
        best = k;
        if (l < count && key_q[l] < key_q[best]) best = l;
        if (l + 1 < count && key_q[l + 1] < key_q[best]) best = l + 1;
        if (best == k) break;
        swap_slots(k, best);
        k = best;
      end
    endfunction

    // note an accepted input transfer and queue its expected result
    function void note_op(in_t op);
      out_t r;
      int i;
      logic [31:0] victim;
      r = '0;
      r.status = ST_OK;
      case (op.operation)
        OP_INSERT: begin
          if (count >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            place(count, op.event_time, op.agent_id);
            count++;
            float_up(count - 1);
          end
        end
        OP_REMOVE, OP_PEEK: begin
          if (count == 0) begin
            r.status = ST_EMPTY;
            r.top_time = '1;
          end else begin
            r.top_agent = who_q[0];
            r.top_time = key_q[0];
            if (op.operation == OP_REMOVE) begin
              count--;
              if (count > 0) begin
                place(0, key_q[count], who_q[count]);
                sink(0);
              end
            end
          end
        end
        default: begin
          i = slot_of[op.agent_id];
          if (!(i < count && who_q[i] == op.agent_id)) begin
            r.status = ST_BAD;
          end else begin
            victim = key_q[i];
            count--;
            if (count > 0 && i != count) begin
              place(i, key_q[count], who_q[count]);
              if (key_q[i] <= victim) float_up(i);
              else sink(i);
            end
          end
        end
      endcase
      r.occupancy = OCC_W'(count);
      pending.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) report($sformatf("status %0d want %0d", got.status, e.status));
      if (got.top_agent !== e.top_agent)
        report($sformatf("top_agent %0d want %0d", got.top_agent, e.top_agent));
      if (got.top_time !== e.top_time)
        report($sformatf("top_time %h want %h", got.top_time, e.top_time));
      if (got.occupancy !== e.occupancy)
        report($sformatf("occupancy %0d want %0d", got.occupancy, e.occupancy));
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  heap_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;

  binary_min_heap_event_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // sample transfers at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_op(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // live agents the stimulus knows about, for well-formed deletes
  int live[$];
  // every agent ever inserted, so a stale delete only looks at written map entries
  int seen[$];

  // valid stays up after a transfer and drops only when the sender idles
  task automatic send_op(op_e op, logic [9:0] a, logic [31:0] t);
    in_t x;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    x.operation = op;
    x.agent_id = a;
    x.event_time = t;
    in_valid_i <= 1'b1;
    in_data_i <= x;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_op();
    int sel;
    logic [9:0] a;
    sel = $urandom_range(99);
    a = 10'($urandom);
    if (sel < 45) begin
      // small key ranges give plenty of ties
      send_op(OP_INSERT, a, $urandom_range(1) ? $urandom : $urandom_range(15));
      live.push_back(a);
      seen.push_back(a);
    end else if (sel < 65) begin
      send_op(OP_REMOVE, a, $urandom);
    end else if (sel < 85 && live.size() > 0) begin
      sel = $urandom_range(live.size() - 1);
      send_op(OP_DELETE, live[sel], $urandom);
      live.delete(sel);
    end else if (sel < 92 && seen.size() > 0) begin
      sel = $urandom_range(seen.size() - 1);
      send_op(OP_DELETE, 10'(seen[sel]), $urandom);
    end else begin
      send_op(OP_PEEK, a, $urandom);
    end
  endtask

  initial begin
    int phase;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty cases, extremes, ties, duplicate agent, last-entry delete
    send_op(OP_PEEK, 10'd0, 32'd0);
    send_op(OP_REMOVE, 10'd0, 32'd0);
    send_op(OP_INSERT, 10'd1023, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 10'd0, 32'd0);
    send_op(OP_INSERT, 10'd7, 32'd100);
    send_op(OP_INSERT, 10'd8, 32'd100);
    send_op(OP_INSERT, 10'd7, 32'd50);
    send_op(OP_PEEK, 10'd0, 32'd0);
    send_op(OP_DELETE, 10'd8, 32'd0);
    send_op(OP_DELETE, 10'd8, 32'd0);
    send_op(OP_DELETE, 10'd0, 32'd0);
    send_op(OP_INSERT, 10'h2AA, 32'hAAAA_AAAA);
    send_op(OP_INSERT, 10'h155, 32'h5555_5555);
    send_op(OP_DELETE, 10'h2AA, 32'd0);
    send_op(OP_REMOVE, 10'd0, 32'd0);
    send_op(OP_REMOVE, 10'd0, 32'd0);
    send_op(OP_REMOVE, 10'd0, 32'd0);
    send_op(OP_REMOVE, 10'd0, 32'd0);
    send_op(OP_REMOVE, 10'd0, 32'd0);
    // delete on an empty heap
    send_op(OP_DELETE, 10'd7, 32'd0);
    drain();
    seen.push_back(0);
    seen.push_back(7);
    seen.push_back(8);
    seen.push_back(10'h155);
    seen.push_back(10'h2AA);
    seen.push_back(1023);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (20) random_op();
    join

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      repeat (125) random_op();
      drain();
    end

    repeat (60) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
